@@ hdl/mpe_chk_pkg.sv @@
// shared types, constants and checksum helper for the mpe section checker
// no dependencies; imported by every module of the block
`default_nettype none

package mpe_chk_pkg;

  localparam int MAX_SECTION_BYTES_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF       = 4;

  // byte counter sized for the top of the section length range
  localparam int CNT_W  = 13;
  localparam int PAY_W  = 13;
  localparam int SUM_W  = 16;
  localparam int DEND_W = 17;

  // bytes 32..37 whose inclusion depends on the udp length
  localparam int UDP_PREFIX = 6;
  localparam int PRE_IDX_W  = $clog2(UDP_PREFIX);

  localparam logic [7:0]       TABLE_ID   = 8'h3E;
  localparam logic [SUM_W-1:0] SUM_OK     = 16'hFFFF;
  localparam logic [7:0]       PROTO_UDP  = 8'd17;
  localparam logic [3:0]       IP_VERSION = 4'd4;

  localparam logic [CNT_W-1:0] IDX_TABLE   = 13'd0;
  localparam logic [CNT_W-1:0] IDX_MAC0    = 13'd3;
  localparam logic [CNT_W-1:0] IDX_MAC1    = 13'd4;
  localparam logic [CNT_W-1:0] IDX_MAC2    = 13'd8;
  localparam logic [CNT_W-1:0] IDX_MAC3    = 13'd9;
  localparam logic [CNT_W-1:0] IDX_MAC4    = 13'd10;
  localparam logic [CNT_W-1:0] IDX_MAC5    = 13'd11;
  localparam logic [CNT_W-1:0] IP_START    = 13'd12;
  localparam logic [CNT_W-1:0] IDX_PROTO   = 13'd21;
  localparam logic [CNT_W-1:0] IDX_SRC     = 13'd24;
  localparam logic [CNT_W-1:0] IDX_DST     = 13'd28;
  localparam logic [CNT_W-1:0] IDX_IP_LAST = 13'd31;
  localparam logic [CNT_W-1:0] UDP_START   = 13'd32;
  localparam logic [CNT_W-1:0] IDX_LEN_HI  = 13'd36;
  localparam logic [CNT_W-1:0] IDX_LEN_LO  = 13'd37;
  localparam logic [CNT_W-1:0] MIN_LEN     = 13'd38;
  localparam logic [CNT_W-1:0] DATA_END    = 13'd56;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TABLE = 3'd1;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd2;
  localparam logic [2:0] ST_IP_CSUM   = 3'd3;
  localparam logic [2:0] ST_NOT_UDP   = 3'd4;
  localparam logic [2:0] ST_UDP_CSUM  = 3'd5;
  localparam logic [2:0] ST_SHORT     = 3'd6;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] sec_len;
    logic             take;
    logic             last;
  } op_t;

  // end-around carry add
  function automatic logic [SUM_W-1:0] csum_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] w);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
  endfunction

endpackage

`default_nettype wire

@@ hdl/mpe_chk_front.sv @@
// front end: accepts section bytes and tags each with its position
// depends on mpe_chk_pkg
`default_nettype none

module mpe_chk_front #(
  parameter int MAX_SECTION_BYTES = mpe_chk_pkg::MAX_SECTION_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        section_byte,
  input  wire logic              last_byte,
  input  wire logic              q_full,
  output logic                   push,
  output mpe_chk_pkg::op_t       push_op
);
  import mpe_chk_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SECTION_BYTES);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             take;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign take     = (count < MAX_CNT);

  always_comb begin
    push_op.data    = section_byte;
    push_op.idx     = count;
    push_op.sec_len = take ? count + 1'b1 : count;
    push_op.take    = take;
    push_op.last    = last_byte;
  end

  always_comb begin
    count_next = count;
    if (push) begin
      if (last_byte) begin
        count_next = '0;
      end else if (take) begin
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mpe_chk_queue.sv @@
// short register queue between front and back
// depends on mpe_chk_pkg for the entry type
`default_nettype none

module mpe_chk_queue #(
  parameter int DEPTH = mpe_chk_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  mpe_chk_pkg::op_t       push_op,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output mpe_chk_pkg::op_t       head
);
  import mpe_chk_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NUM_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [NUM_W-1:0] NUM_FULL = NUM_W'(DEPTH);

  op_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [NUM_W-1:0] num;
  logic             do_pop;

  assign full      = (num == NUM_FULL);
  assign not_empty = (num != '0);
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      num    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        num <= num + 1'b1;
      end else if (!push && do_pop) begin
        num <= num - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/mpe_chk_back.sv @@
// back end: per-byte checks and checksums, then a short finishing pipeline
// depends on mpe_chk_pkg
`default_nettype none

module mpe_chk_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  mpe_chk_pkg::op_t       q_op,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             status,
  output logic [47:0]            dest_mac,
  output logic [31:0]            source_ip,
  output logic [31:0]            dest_ip,
  output logic [15:0]            udp_length,
  output logic [12:0]            payload_length
);
  import mpe_chk_pkg::*;

  typedef logic [UDP_PREFIX-1:0][SUM_W-1:0] pre_t;

  typedef struct packed {
    logic [2:0]        early;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  udp;
    logic [15:0]       len;
    logic [DEND_W-1:0] data_end;
    logic [7:0]        proto;
    pre_t              pre;
    logic [47:0]       mac;
    logic [31:0]       src;
    logic [31:0]       dst;
  } snap_t;

  typedef struct packed {
    logic [2:0]       st_fixed;
    logic             use_udp;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    logic [47:0]      mac;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [15:0]      len;
    logic [PAY_W-1:0] pay;
  } fin_t;

  // running section state
  logic [2:0]        early,    early_next;
  logic [SUM_W-1:0]  ip_sum,   ip_sum_next;
  logic [SUM_W-1:0]  udp_sum,  udp_sum_next;
  logic [SUM_W-1:0]  run,      run_next;
  pre_t              pre,      pre_next;
  logic [7:0]        hold,     hold_next;
  logic [47:0]       mac,      mac_next;
  logic [7:0]        proto,    proto_next;
  logic [31:0]       src,      src_next;
  logic [31:0]       dst,      dst_next;
  logic [15:0]       len,      len_next;
  logic [DEND_W-1:0] data_end, data_end_next;

  logic              adv;
  logic              s_valid;
  snap_t             snap;
  logic              f_valid;
  fin_t              fin;

  logic [7:0]           b;
  logic [CNT_W-1:0]     idx;
  logic [SUM_W-1:0]     word;
  logic [PRE_IDX_W-1:0] pidx;

  assign adv  = !out_valid || !out_stall;
  assign pop  = q_valid && adv;
  assign b    = q_op.data;
  assign idx  = q_op.idx;
  assign word = idx[0] ? {8'h00, b} : {b, 8'h00};
  assign pidx = PRE_IDX_W'(idx - UDP_START);

  always_comb begin
    early_next    = early;
    ip_sum_next   = ip_sum;
    udp_sum_next  = udp_sum;
    run_next      = run;
    pre_next      = pre;
    hold_next     = hold;
    mac_next      = mac;
    proto_next    = proto;
    src_next      = src;
    dst_next      = dst;
    len_next      = len;
    data_end_next = data_end;
    if (q_op.take) begin
      if (idx == IDX_TABLE && b != TABLE_ID && early == ST_OK) begin
        early_next = ST_BAD_TABLE;
      end
      if (idx == IDX_MAC0) mac_next[7:0]   = b;
      if (idx == IDX_MAC1) mac_next[15:8]  = b;
      if (idx == IDX_MAC2) mac_next[23:16] = b;
      if (idx == IDX_MAC3) mac_next[31:24] = b;
      if (idx == IDX_MAC4) mac_next[39:32] = b;
      if (idx == IDX_MAC5) mac_next[47:40] = b;
      if (idx >= IP_START && idx < UDP_START) begin
        ip_sum_next = csum_add(ip_sum, word);
        if (idx == IP_START && b[7:4] != IP_VERSION && early == ST_OK) begin
          early_next = ST_NOT_IPV4;
        end
        if (idx == IDX_PROTO) proto_next = b;
        if (idx >= IDX_SRC && idx < IDX_DST) src_next = {src[23:0], b};
        if (idx >= IDX_DST) dst_next = {dst[23:0], b};
        if (idx >= IDX_SRC) udp_sum_next = csum_add(udp_sum, word);
        if (idx == IDX_IP_LAST && early == ST_OK) begin
          if (ip_sum_next != SUM_OK) begin
            early_next = ST_IP_CSUM;
          end else if (proto != PROTO_UDP) begin
            early_next = ST_NOT_UDP;
          end
        end
      end
      // udp header bytes: keep every prefix sum until the length is known
      if (idx >= UDP_START && idx <= IDX_LEN_LO) begin
        run_next       = csum_add((idx == UDP_START) ? '0 : run, word);
        pre_next[pidx] = run_next;
      end
      if (idx == IDX_LEN_HI) hold_next = b;
      if (idx == IDX_LEN_LO) begin
        len_next      = {hold, b};
        data_end_next = DEND_W'(len_next) + DEND_W'(UDP_START);
      end
      if (idx > IDX_LEN_LO && DEND_W'(idx) < data_end) begin
        udp_sum_next = csum_add(udp_sum, word);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      early    <= ST_OK;
      ip_sum   <= '0;
      udp_sum  <= '0;
      run      <= '0;
      pre      <= '0;
      hold     <= '0;
      mac      <= '0;
      proto    <= '0;
      src      <= '0;
      dst      <= '0;
      len      <= '0;
      data_end <= '0;
    end else if (pop) begin
      if (q_op.last) begin
        early    <= ST_OK;
        ip_sum   <= '0;
        udp_sum  <= '0;
        run      <= '0;
        pre      <= '0;
        hold     <= '0;
        mac      <= '0;
        proto    <= '0;
        src      <= '0;
        dst      <= '0;
        len      <= '0;
        data_end <= '0;
      end else begin
        early    <= early_next;
        ip_sum   <= ip_sum_next;
        udp_sum  <= udp_sum_next;
        run      <= run_next;
        pre      <= pre_next;
        hold     <= hold_next;
        mac      <= mac_next;
        proto    <= proto_next;
        src      <= src_next;
        dst      <= dst_next;
        len      <= len_next;
        data_end <= data_end_next;
      end
    end
  end

  // snapshot of the finished section
  always_ff @(posedge clk) begin
    if (adv) begin
      snap.early    <= early_next;
      snap.count    <= q_op.sec_len;
      snap.udp      <= udp_sum_next;
      snap.len      <= len_next;
      snap.data_end <= data_end_next;
      snap.proto    <= proto_next;
      snap.pre      <= pre_next;
      snap.mac      <= mac_next;
      snap.src      <= src_next;
      snap.dst      <= dst_next;
    end
  end

  // finishing stage: prefix pick, partial sums, length checks
  logic [PRE_IDX_W-1:0] k;
  logic [SUM_W-1:0]     pre_sel;
  logic                 short_sec;

  assign k = snap.len[PRE_IDX_W-1:0];

  always_comb begin
    if (snap.len >= 16'(UDP_PREFIX)) begin
      pre_sel = snap.pre[UDP_PREFIX-1];
    end else if (k == '0) begin
      pre_sel = '0;
    end else begin
      pre_sel = snap.pre[k - 1'b1];
    end
    short_sec = (snap.count < MIN_LEN) || (snap.data_end > DEND_W'(snap.count));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin.sum_a    <= csum_add(snap.udp, pre_sel);
      fin.sum_b    <= csum_add(snap.len, {8'h00, snap.proto});
      fin.st_fixed <= (snap.early != ST_OK) ? snap.early : ST_SHORT;
      fin.use_udp  <= (snap.early == ST_OK) && !short_sec;
      fin.mac      <= snap.mac;
      fin.src      <= snap.src;
      fin.dst      <= snap.dst;
      fin.len      <= snap.len;
      fin.pay      <= (snap.count > DATA_END) ? PAY_W'(snap.count - DATA_END) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.use_udp) begin
        status <= (csum_add(fin.sum_a, fin.sum_b) == SUM_OK) ? ST_OK : ST_UDP_CSUM;
      end else begin
        status <= fin.st_fixed;
      end
      dest_mac       <= fin.mac;
      source_ip      <= fin.src;
      dest_ip        <= fin.dst;
      udp_length     <= fin.len;
      payload_length <= fin.pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s_valid   <= pop && q_op.last;
      f_valid   <= s_valid;
      out_valid <= f_valid;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mpe_ipv4_udp_section_checker_core.sv @@
// a last byte goes through a queue entry, then the s_valid, f_valid and out_valid registers
// throughput: one section byte per cycle while in_stall is low; one result per section, at its last byte
// the rate is set by the back end, which folds one byte per cycle into each checksum
// output stall freezes the back end; the 4-entry queue then absorbs input until full
// synchronous reset clears byte counter, queue, section sums and all valid flags
`default_nettype none

module mpe_ipv4_udp_section_checker_core #(
  parameter int MAX_SECTION_BYTES = mpe_chk_pkg::MAX_SECTION_BYTES_DEF,
  parameter int QUEUE_DEPTH       = mpe_chk_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // byte channel
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   section_byte,
  input  wire logic         last_byte,
  // result channel
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        status,
  output logic [47:0]       dest_mac,
  output logic [31:0]       source_ip,
  output logic [31:0]       dest_ip,
  output logic [15:0]       udp_length,
  output logic [12:0]       payload_length
);
  import mpe_chk_pkg::*;

  // front to queue
  logic push;
  op_t  push_op;
  logic q_full;

  // queue to back
  logic q_valid;
  op_t  q_op;
  logic pop;

  // front: counts bytes in the section, tags position, saturation and length
  mpe_chk_front #(
    .MAX_SECTION_BYTES (MAX_SECTION_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .section_byte (section_byte),
    .last_byte    (last_byte),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op)
  );

  // queue: lets the front keep taking transactions while the result side stalls, until it fills
  mpe_chk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_op)
  );

  // back: table, version, ip checksum, protocol checks, udp sum, then
  // a finishing pipeline that adds pseudo-header terms and picks the status
  mpe_chk_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .dest_mac       (dest_mac),
    .source_ip      (source_ip),
    .dest_ip        (dest_ip),
    .udp_length     (udp_length),
    .payload_length (payload_length)
  );

endmodule

`default_nettype wire

@@ hdl/mpe_chk_checker.sv @@
// port-level assertions for the section checker, bound to the top level
// depends on mpe_chk_pkg for status codes
`default_nettype none

module mpe_chk_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  status,
  input wire logic [15:0] udp_length,
  input wire logic [12:0] payload_length
);
  import mpe_chk_pkg::*;

  // a pending result survives a stall
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // reset leaves no stale result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_SHORT)
    else $error("undefined status code");

  // a passing section holds the whole udp datagram: 32 + len <= section length
  a_ok_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK && udp_length > 16'd24
      |-> 17'(payload_length) + 17'd24 >= 17'(udp_length))
    else $error("ok status on a section shorter than its datagram");

endmodule

bind mpe_ipv4_udp_section_checker_core mpe_chk_checker u_chk (.*);

`default_nettype wire
